// File: src/b64e_pkg.sv
package b64e_pkg;

   // Characters that are not part of the base64 alphabet.
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   // Positions of the character sequencer in the back end.
   // The newline goes first; the four symbols follow it.
   localparam logic [2:0] STEP_NEWLINE = 3'd0;
   localparam logic [2:0] STEP_FIRST   = 3'd1;
   localparam logic [2:0] STEP_SECOND  = 3'd2;
   localparam logic [2:0] STEP_THIRD   = 3'd3;
   localparam logic [2:0] STEP_LAST    = 3'd4;

   // Number of jobs that the queue between front and back can hold.
   // This must be a power of two.
   localparam int unsigned QUEUE_DEPTH = 2;

   // One group of up to three bytes, with the first byte in the top bits.
   // Missing bytes of a short group are zero.
   typedef struct packed {
      logic [23:0] group_bytes;
      logic [1:0]  byte_count;
      logic        newline;
      logic        last;
   } job_type;

   function automatic logic [7:0] b64_symbol(input logic [5:0] value);
      logic [7:0] result;
      begin
         if (value < 6'd26) begin
            result = 8'h41 + {2'b00, value};
         end else if (value < 6'd52) begin
            result = 8'h61 + {2'b00, value - 6'd26};
         end else if (value < 6'd62) begin
            result = 8'h30 + {2'b00, value - 6'd52};
         end else if (value == 6'd62) begin
            result = 8'h2B;
         end else begin
            result = 8'h2F;
         end
         return result;
      end
   endfunction

endpackage

// File: src/base64_stream_encoder_unit.sv
// Base64 encoder for a byte stream. Each req beat carries one message byte
// in req_tdata, with req_tlast on the final byte; each rsp beat carries one
// ASCII character, with rsp_tlast on the final character of the message.
// Every three bytes give four symbols, and a newline goes out ahead of a full
// group once GROUPS_PER_LINE groups are on the current line; a short tail is
// padded with '=' and is never preceded by a newline. A message must hold at
// least one byte. The front end takes one byte per cycle while its two-job
// queue has room; the back end sends one character per cycle from its single
// character output register while the receiver is ready. The last byte of a
// group passes through the queue and the job register before the first
// character of that group is registered for output.
module base64_stream_encoder_unit #(
   parameter int unsigned GROUPS_PER_LINE = 19
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast
);

   b64e_pkg::job_type push_job;
   b64e_pkg::job_type pop_job;
   logic              push;
   logic              queue_full;
   logic              pop;
   logic              pop_valid;

   b64e_front #(
      .GROUPS_PER_LINE(GROUPS_PER_LINE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   b64e_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_job   (pop_job)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: src/b64e_front.sv
module b64e_front #(
   parameter int unsigned GROUPS_PER_LINE = 19
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   input  logic             queue_full,
   output logic             push,
   output b64e_pkg::job_type push_job
);

   localparam int unsigned LineCntW = $clog2(GROUPS_PER_LINE + 1);

   logic [7:0]          held0_ff, held0_in;
   logic [7:0]          held1_ff, held1_in;
   logic [1:0]          phase_ff, phase_in;
   logic [LineCntW-1:0] groups_ff, groups_in;

   logic accept;
   logic full_group;
   logic line_full;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign full_group = (phase_ff == 2'd2);
   assign line_full  = (groups_ff >= LineCntW'(GROUPS_PER_LINE));
   assign push       = accept && (full_group || req_tlast);

   always_comb begin
      push_job.last    = req_tlast;
      push_job.newline = full_group && line_full;
      if (full_group) begin
         push_job.group_bytes = {held0_ff, held1_ff, req_tdata};
         push_job.byte_count  = 2'd3;
      end else if (phase_ff == 2'd1) begin
         push_job.group_bytes = {held0_ff, req_tdata, 8'h00};
         push_job.byte_count  = 2'd2;
      end else begin
         push_job.group_bytes = {req_tdata, 16'h0000};
         push_job.byte_count  = 2'd1;
      end
   end

   always_comb begin
      held0_in  = held0_ff;
      held1_in  = held1_ff;
      phase_in  = phase_ff;
      groups_in = groups_ff;
      if (accept) begin
         if (req_tlast) begin
            phase_in  = 2'd0;
            groups_in = '0;
         end else if (full_group) begin
            phase_in  = 2'd0;
            groups_in = line_full ? LineCntW'(1) : groups_ff + LineCntW'(1);
         end else begin
            if (phase_ff[0]) begin
               held1_in = req_tdata;
            end else begin
               held0_in = req_tdata;
            end
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      if (reset) begin
         phase_ff  <= 2'd0;
         groups_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         groups_ff <= groups_in;
      end
   end

   phase_range_a: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("front holds more than two bytes");

   newline_only_full_a: assert property (@(posedge clock) disable iff (reset)
      (push && push_job.newline) |-> (push_job.byte_count == 2'd3))
      else $error("newline requested ahead of a tail");

   line_count_a: assert property (@(posedge clock) disable iff (reset)
      groups_ff <= LineCntW'(GROUPS_PER_LINE))
      else $error("line group count overran");

endmodule

// File: src/b64e_queue.sv
module b64e_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  b64e_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output b64e_pkg::job_type pop_job
);

   localparam int unsigned Depth = b64e_pkg::QUEUE_DEPTH;
   localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW  = $clog2(Depth + 1);

   b64e_pkg::job_type entries_ff [Depth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full      = (count_ff == CntW'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/b64e_back.sv
module b64e_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  b64e_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   b64e_pkg::job_type job_ff, job_in;
   logic              active_ff, active_in;
   logic [2:0]        step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [7:0]        char_ff, char_in;
   logic              last_ff, last_in;

   logic       advance;
   logic       emit;
   logic       finish;
   logic [5:0] sextet;
   logic [7:0] cur_char;

   assign advance = !valid_ff || rsp_tready;
   assign emit    = advance && active_ff;
   assign finish  = emit && (step_ff == b64e_pkg::STEP_LAST);
   assign job_pop = job_valid && (!active_ff || finish);

   always_comb begin
      case (step_ff)
         b64e_pkg::STEP_FIRST:  sextet = job_ff.group_bytes[23:18];
         b64e_pkg::STEP_SECOND: sextet = job_ff.group_bytes[17:12];
         b64e_pkg::STEP_THIRD:  sextet = job_ff.group_bytes[11:6];
         default:               sextet = job_ff.group_bytes[5:0];
      endcase
      // Symbol positions beyond the bytes present are padding.
      if (step_ff == b64e_pkg::STEP_NEWLINE) begin
         cur_char = b64e_pkg::CHAR_NEWLINE;
      end else if (step_ff > ({1'b0, job_ff.byte_count} + 3'd1)) begin
         cur_char = b64e_pkg::CHAR_PAD;
      end else begin
         cur_char = b64e_pkg::b64_symbol(sextet);
      end
   end

   always_comb begin
      job_in    = job_ff;
      active_in = active_ff;
      step_in   = step_ff;
      valid_in  = valid_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      if (advance) begin
         valid_in = active_ff;
         char_in  = cur_char;
         last_in  = job_ff.last && (step_ff == b64e_pkg::STEP_LAST);
      end
      if (job_pop) begin
         job_in    = job;
         active_in = 1'b1;
         step_in   = job.newline ? b64e_pkg::STEP_NEWLINE : b64e_pkg::STEP_FIRST;
      end else if (finish) begin
         active_in = 1'b0;
      end else if (emit) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      step_ff <= step_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

   step_range_a: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (step_ff <= b64e_pkg::STEP_LAST))
      else $error("character step out of range");

   newline_step_a: assert property (@(posedge clock) disable iff (reset)
      (active_ff && step_ff == b64e_pkg::STEP_NEWLINE) |-> job_ff.newline)
      else $error("newline step on a job without newline");

   last_char_a: assert property (@(posedge clock) disable iff (reset)
      (emit && job_ff.last && step_ff == b64e_pkg::STEP_LAST) |=> (valid_ff && last_ff))
      else $error("final character of a message not marked");

endmodule

// File: verif/base64_stream_encoder_unit_tb.sv
`timescale 1ns / 100ps

module base64_stream_encoder_unit_tb;

   localparam int unsigned LINE_GROUPS = 19;
   localparam int unsigned STUCK_LIMIT = 5000;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned RANDOM_BYTES = 480;

   // First symbol sits in the top byte of the literal.
   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_MOSTLY
   } ready_mode_type;

   class b64_encode_scoreboard;
      typedef struct {
         logic [7:0] out_char;
         logic       last_char;
      } enc_char_type;

      enc_char_type pending_chars[$];
      logic [7:0] held[2];
      logic [1:0] phase;
      logic [4:0] line_groups;
      int         failures;

      function new();
         failures = 0;
         restart();
      endfunction

      function void restart();
         held[0] = 8'h00;
         held[1] = 8'h00;
         phase = 2'd0;
         line_groups = 5'd0;
      endfunction

      function logic [7:0] symbol(input logic [5:0] value);
         return ALPHABET[8 * (63 - int'(value)) +: 8];
      endfunction

      function void push(input logic [7:0] ch, input logic is_last);
         enc_char_type item;
         item.out_char = ch;
         item.last_char = is_last;
         pending_chars.push_back(item);
      endfunction

      function void note_byte(input logic [7:0] b, input logic is_last);
         logic [7:0] c1;
         logic [7:0] c2;
         c1 = held[0];
         c2 = held[1];
         if (phase == 2'd2) begin
            if (line_groups >= LINE_GROUPS) begin
               push(b64e_pkg::CHAR_NEWLINE, 1'b0);
               line_groups = 5'd0;
            end
            push(symbol(c1[7:2]), 1'b0);
            push(symbol({c1[1:0], c2[7:4]}), 1'b0);
            push(symbol({c2[3:0], b[7:6]}), 1'b0);
            push(symbol(b[5:0]), is_last);
            line_groups = line_groups + 5'd1;
            phase = 2'd0;
            held[0] = 8'h00;
            held[1] = 8'h00;
         end else if (!is_last) begin
            held[phase[0]] = b;
            phase = phase + 2'd1;
         end else if (phase == 2'd0) begin
            push(symbol(b[7:2]), 1'b0);
            push(symbol({b[1:0], 4'b0000}), 1'b0);
            push(b64e_pkg::CHAR_PAD, 1'b0);
            push(b64e_pkg::CHAR_PAD, 1'b1);
         end else begin
            push(symbol(c1[7:2]), 1'b0);
            push(symbol({c1[1:0], b[7:4]}), 1'b0);
            push(symbol({b[3:0], 2'b00}), 1'b0);
            push(b64e_pkg::CHAR_PAD, 1'b1);
         end
         // The encoder starts over after the final byte of a message.
         if (is_last) begin
            restart();
         end
      endfunction

      function void check_char(input logic [7:0] ch, input logic is_last);
         enc_char_type want;
         if (pending_chars.size() == 0) begin
            $error("unexpected character beat: out_char %h last_char %b", ch, is_last);
            failures++;
            return;
         end
         want = pending_chars.pop_front();
         if (ch !== want.out_char) begin
            $error("out_char mismatch: expected %h, actual %h", want.out_char, ch);
            failures++;
         end
         if (is_last !== want.last_char) begin
            $error("last_char mismatch: expected %b, actual %b", want.last_char, is_last);
            failures++;
         end
      endfunction

      function int chars_pending();
         return pending_chars.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   b64_encode_scoreboard encoder_sb = new();

   int             burst_left = 0;
   int             random_bytes_sent = 0;
   int             hold_ask = 0;
   int             hold_done = 0;
   int             hold_left = 0;
   int             mode_left = 0;
   int             sparse_count = 0;
   int             stuck_cycles = 0;
   ready_mode_type ready_mode = READY_ALWAYS;

   base64_stream_encoder_unit #(
      .GROUPS_PER_LINE(LINE_GROUPS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Offer one byte, which may open a gap first when the current burst is used up.
   task automatic send_byte(input logic [7:0] value, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= is_last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Bytes of a short directed message, first byte in the low bits.
   task automatic send_pattern(input int len, input logic [39:0] bytes);
      for (int i = 0; i < len; i++) begin
         send_byte(bytes[8*i +: 8], i == len - 1);
      end
   endtask

   task automatic send_random(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
         random_bytes_sent++;
      end
   endtask

   // Beat monitor and receiver. Input beats are noted before output beats are
   // checked so that both sides of one edge are seen in a fixed order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            encoder_sb.note_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            encoder_sb.check_char(rsp_tdata, rsp_tlast);
         end
         if (hold_done != hold_ask) begin
            hold_done = hold_ask;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         sparse_count = (sparse_count + 1) % 4;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_tready <= (sparse_count == 0);
               default:      rsp_tready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
         end
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      int len;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-byte tails at both extremes, then two-byte tails.
      send_pattern(1, 40'h00);
      send_pattern(1, 40'hFF);
      send_pattern(2, 40'h00FF);
      send_pattern(2, 40'hFF00);
      // Messages that end on a full group.
      send_pattern(3, 40'h000000);
      send_pattern(3, 40'hFFFFFF);
      send_pattern(3, 40'h6E614D);
      // A full group followed by each tail length.
      send_pattern(4, 40'hF00F03FC);
      send_pattern(5, 40'h55FE017F80);

      // The receiver backs off for a long stretch while bytes keep coming.
      hold_ask++;
      // Nineteen groups fill a line, so the twentieth is the last group and
      // gets a newline ahead of it.
      send_random(60);
      while (random_bytes_sent < RANDOM_BYTES) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            len = $urandom_range(1, 9);
         end else if (pick <= 8) begin
            len = $urandom_range(57, 63);
         end else begin
            len = $urandom_range(112, 125);
         end
         // The last message is cut short so the byte total ends exactly on the target.
         if (len > RANDOM_BYTES - random_bytes_sent) begin
            len = RANDOM_BYTES - random_bytes_sent;
         end
         if (random_bytes_sent > RANDOM_BYTES / 2 && hold_ask == 1) begin
            hold_ask++;
         end
         send_random(len);
      end
      req_tvalid <= 1'b0;

      while (encoder_sb.chars_pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (encoder_sb.failures == 0 && encoder_sb.chars_pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: files.f
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder_unit.sv
verif/base64_stream_encoder_unit_tb.sv
